FILE: sv/quadruped_gait_oscillator_defines.svh
// Assertion macros for the verification checker of the gait oscillator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef QUADRUPED_GAIT_OSCILLATOR_DEFINES_SVH
`define QUADRUPED_GAIT_OSCILLATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QGO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QGO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/qgo_pkg.sv
`timescale 1ns / 1ps

package qgo_pkg;

    // Default sizes of the phase accumulator and of the sine table address.
    localparam int PHASE_BITS_DEFAULT     = 16;
    localparam int SINE_ADDR_BITS_DEFAULT = 10;

    // Field and register widths.
    localparam int KEY_W    = 3;
    localparam int POS_W    = 14;
    localparam int AMP_W    = 6;
    localparam int SPINE_W  = 4;
    localparam int STEP_W   = 16;
    localparam int GAIN_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SINE_W   = 15;

    // Leg arithmetic widths.
    localparam int AMP_MAG_W  = 5;
    localparam int AMP_GAIN_W = AMP_MAG_W + GAIN_W;
    localparam int PROD_W     = AMP_GAIN_W + SINE_W;
    localparam int SCALED_W   = PROD_W + 1 - 12;
    localparam int RECIP_W    = 16;
    localparam int QMUL_W     = SCALED_W + RECIP_W;
    localparam int QUOT_W     = QMUL_W - 18;
    localparam int SUM_W      = POS_W + 3;

    // Dividing by 20480 is a shift by 12 and a divide by 5, with half added first.
    localparam logic [PROD_W:0]    ROUND_BIAS  = (PROD_W + 1)'(10240);
    localparam int                 ROUND_SHIFT = 12;
    localparam logic [RECIP_W-1:0] DIV5_RECIP  = 16'd52429;
    localparam int                 DIV5_SHIFT  = 18;

    // Limits of the stepped quantities.
    localparam logic signed [SPINE_W-1:0] SPINE_MAX = 4'sd6;
    localparam logic signed [SPINE_W-1:0] SPINE_MIN = -4'sd6;
    localparam logic signed [AMP_W-1:0]   AMP_MAX   = 6'sd17;
    localparam logic signed [AMP_W-1:0]   AMP_MIN   = -6'sd17;
    localparam logic signed [AMP_W-1:0]   AMP_RESET = 6'sd10;
    localparam logic signed [POS_W-1:0]   POS_MAX   = 14'sd8191;
    localparam logic signed [POS_W-1:0]   POS_MIN   = -14'sd8192;

    // Configuration register reset values.
    localparam logic [STEP_W-1:0]        PHASE_STEP_RESET  = 16'd1783;
    localparam logic [STEP_W-1:0]        HIND_PHASE_RESET  = 16'd20861;
    localparam logic [GAIN_W-1:0]        FRONT_GAIN_RESET  = 8'd128;
    localparam logic [GAIN_W-1:0]        HIND_GAIN_RESET   = 8'd205;
    localparam logic signed [POS_W-1:0]  FRONT_OFFSET_RESET = 14'sd410;
    localparam logic signed [POS_W-1:0]  HIND_OFFSET_RESET  = -14'sd819;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIND_PHASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIND_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIND_OFFSET  = 3'd5;

    // Key codes carried by each tick.
    typedef enum logic [KEY_W-1:0] {
        KEY_NONE  = 3'd0,
        KEY_LEFT  = 3'd1,
        KEY_RIGHT = 3'd2,
        KEY_UP    = 3'd3,
        KEY_DOWN  = 3'd4,
        KEY_STOP  = 3'd5,
        KEY_RUN   = 3'd6,
        KEY_OTHER = 3'd7
    } key_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_PRODUCT,
        ST_ROUND,
        ST_FINISH
    } gait_state_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load_item;
        logic scale;
        logic product;
        logic round;
        logic load_out;
    } gait_cmd_t;

    // First-quadrant sine entry in Q15, evaluated at elaboration time.
    // The angle is taken to Q30 and summed by the Taylor series up to x^13.
    function automatic logic [SINE_W-1:0] quarter_sine(input int h, input int abits);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint r;
        x = (longint'(h) * 64'sd6746518852) >>> abits;
        x2 = (x * x) >>> 30;
        term = x;
        sum = x;
        // Each term is the previous one times -x^2 over (2k)(2k+1), all in Q30.
        term = (-(term * x2)) / 64'sd6442450944;
        sum = sum + term;
        term = (-(term * x2)) / 64'sd21474836480;
        sum = sum + term;
        term = (-(term * x2)) / 64'sd45097156608;
        sum = sum + term;
        term = (-(term * x2)) / 64'sd77309411328;
        sum = sum + term;
        term = (-(term * x2)) / 64'sd118111600640;
        sum = sum + term;
        term = (-(term * x2)) / 64'sd167503724544;
        sum = sum + term;
        if (sum < 0)
        begin
            sum = 0;
        end
        r = (sum + 64'sd16384) >>> 15;
        if (r > 32767)
        begin
            r = 32767;
        end
        return SINE_W'(r);
    endfunction

    // Spine target in Q12 radians for a position in tenths, rounded half away from zero.
    function automatic logic signed [POS_W-1:0] spine_q12(input logic signed [SPINE_W-1:0] t);
        logic [SPINE_W-1:0]       mag;
        logic signed [POS_W-1:0]  val;
        mag = t[SPINE_W-1] ? SPINE_W'(-t) : SPINE_W'(t);
        unique case (mag)
            4'd1:    val = 14'sd410;
            4'd2:    val = 14'sd819;
            4'd3:    val = 14'sd1229;
            4'd4:    val = 14'sd1638;
            4'd5:    val = 14'sd2048;
            4'd6:    val = 14'sd2458;
            default: val = 14'sd0;
        endcase
        return t[SPINE_W-1] ? -val : val;
    endfunction

endpackage

FILE: sv/quadruped_gait_oscillator.sv
// Quadruped gait oscillator: one control tick in, one set of joint targets out.
// Input channel: in_valid, in_stall and key_code; a tick transfers on a clock
// edge with in_valid high and in_stall low. Output channel: out_valid, out_stall
// and the seven result fields; a result transfers with out_valid high and
// out_stall low. Registers are written through cfg_write, cfg_index, cfg_data;
// write them only while no tick is in flight; the block does not enforce it.
// The sine table is read at the transfer edge, then the amplitude-gain multiply,
// the sine multiply and the divide by 20480 are each registered in turn before
// the result register loads.
// A new tick is not taken while one is computed: the next tick is taken in the
// cycle the result register loads.
// A full result register holds its content while out_stall is high; the
// block then finishes the next tick and waits, raising in_stall.
// Reset clears the gait state to no key, spine centered, amplitude ten tenths,
// running, phase zero, and loads the register defaults; no result is valid.
`timescale 1ns / 1ps

module quadruped_gait_oscillator
    import qgo_pkg::*;
#(
    parameter int PHASE_BITS     = PHASE_BITS_DEFAULT,
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [KEY_W-1:0]         key_code,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [POS_W-1:0]  front_position,
    output logic signed [POS_W-1:0]  hind_position,
    output logic                     legs_valid,
    output logic signed [POS_W-1:0]  spine_position,
    output logic                     spine_changed,
    output logic signed [AMP_W-1:0]  amplitude_level,
    output logic                     is_running,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    gait_cmd_t cmd;

    // Sequencer.
    qgo_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Gait state, leg arithmetic and result register.
    qgo_datapath #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .key_code        (key_code),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .front_position  (front_position),
        .hind_position   (hind_position),
        .legs_valid      (legs_valid),
        .spine_position  (spine_position),
        .spine_changed   (spine_changed),
        .amplitude_level (amplitude_level),
        .is_running      (is_running)
    );

endmodule

FILE: sv/qgo_ctrl.sv
`timescale 1ns / 1ps

module qgo_ctrl
    import qgo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output gait_cmd_t cmd
);

    gait_state_t state_reg;
    gait_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        can_load;

    // The result register is free when empty or when its content transfers now.
    assign can_load = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:   state_next = ST_PRODUCT;
            ST_PRODUCT: state_next = ST_ROUND;
            ST_ROUND:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (can_load)
                begin
                    state_next = in_valid ? ST_SCALE : ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs: a new tick is taken when idle or when the finished result can load into the result register.
    always_comb
    begin
        in_stall      = !((state_reg == ST_IDLE) || ((state_reg == ST_FINISH) && can_load));
        cmd.load_item = in_valid && !in_stall;
        cmd.scale     = (state_reg == ST_SCALE);
        cmd.product   = (state_reg == ST_PRODUCT);
        cmd.round     = (state_reg == ST_ROUND);
        cmd.load_out  = (state_reg == ST_FINISH) && can_load;
    end

    // Result valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: sv/qgo_datapath.sv
`timescale 1ns / 1ps

module qgo_datapath
    import qgo_pkg::*;
#(
    parameter int PHASE_BITS     = PHASE_BITS_DEFAULT,
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  gait_cmd_t                 cmd,
    input  logic [KEY_W-1:0]          key_code,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    output logic signed [POS_W-1:0]   front_position,
    output logic signed [POS_W-1:0]   hind_position,
    output logic                      legs_valid,
    output logic signed [POS_W-1:0]   spine_position,
    output logic                      spine_changed,
    output logic signed [AMP_W-1:0]   amplitude_level,
    output logic                      is_running
);

    localparam int QUARTER = 2 ** (SINE_ADDR_BITS - 2);
    localparam int H_BITS  = SINE_ADDR_BITS - 1;
    localparam int WIDE_W  = PHASE_BITS + SINE_ADDR_BITS;
    localparam logic [SINE_ADDR_BITS-1:0] HALF = SINE_ADDR_BITS'(2 ** (SINE_ADDR_BITS - 1));
    localparam logic [H_BITS-1:0]         QUARTER_IDX = H_BITS'(QUARTER);

    // Configuration registers.
    logic [STEP_W-1:0]       phase_step_reg;
    logic [STEP_W-1:0]       hind_phase_reg;
    logic [GAIN_W-1:0]       front_gain_reg;
    logic [GAIN_W-1:0]       hind_gain_reg;
    logic signed [POS_W-1:0] front_offset_reg;
    logic signed [POS_W-1:0] hind_offset_reg;

    // Gait state.
    key_t                      last_key_reg;
    key_t                      last_key_next;
    logic signed [SPINE_W-1:0] spine_tenths_reg;
    logic signed [SPINE_W-1:0] spine_tenths_next;
    logic signed [AMP_W-1:0]   amplitude_tenths_reg;
    logic signed [AMP_W-1:0]   amplitude_tenths_next;
    logic                      run_flag_reg;
    logic                      run_flag_next;
    logic                      changed_reg;
    logic                      changed_next;
    logic [PHASE_BITS-1:0]     phase_acc_reg;
    logic [PHASE_BITS-1:0]     phase_acc_next;
    key_t                      key;

    // Lane 0 is the front leg, lane 1 the hind leg.
    logic [PHASE_BITS-1:0]     lane_phase [2];
    logic [H_BITS-1:0]         lane_h [2];
    logic                      lane_neg [2];
    logic [GAIN_W-1:0]         lane_gain [2];
    logic signed [POS_W-1:0]   lane_offset [2];
    logic signed [POS_W-1:0]   lane_result [2];

    logic [SINE_W-1:0]         sine_mag_reg [2];
    logic                      sine_neg_reg [2];
    logic [AMP_GAIN_W-1:0]     amp_gain_reg [2];
    logic                      sign_reg [2];
    logic [PROD_W-1:0]         prod_reg [2];
    logic [QMUL_W-1:0]         qmul_reg [2];
    logic [AMP_MAG_W-1:0]      amp_mag;

    // Result registers.
    logic signed [POS_W-1:0]   front_position_reg;
    logic signed [POS_W-1:0]   hind_position_reg;
    logic                      legs_valid_reg;
    logic signed [POS_W-1:0]   spine_position_reg;
    logic                      spine_changed_reg;
    logic signed [AMP_W-1:0]   amplitude_level_reg;
    logic                      is_running_reg;

    // Quarter-wave sine table.
    logic [SINE_W-1:0]         sine_rom [QUARTER + 1];

    genvar gi;
    generate
        for (gi = 0; gi <= QUARTER; gi++)
        begin : g_rom
            assign sine_rom[gi] = quarter_sine(gi, SINE_ADDR_BITS);
        end
    endgenerate

    // Configuration writes; bits above a register's width are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= PHASE_STEP_RESET;
            hind_phase_reg   <= HIND_PHASE_RESET;
            front_gain_reg   <= FRONT_GAIN_RESET;
            hind_gain_reg    <= HIND_GAIN_RESET;
            front_offset_reg <= FRONT_OFFSET_RESET;
            hind_offset_reg  <= HIND_OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                CFG_HIND_PHASE:   hind_phase_reg   <= cfg_data;
                CFG_FRONT_GAIN:   front_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_HIND_GAIN:    hind_gain_reg    <= cfg_data[GAIN_W-1:0];
                CFG_FRONT_OFFSET: front_offset_reg <= cfg_data[POS_W-1:0];
                CFG_HIND_OFFSET:  hind_offset_reg  <= cfg_data[POS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Key handling: only a key that differs from the previous tick acts.
    assign key = key_t'(key_code);

    always_comb
    begin
        last_key_next         = last_key_reg;
        spine_tenths_next     = spine_tenths_reg;
        amplitude_tenths_next = amplitude_tenths_reg;
        run_flag_next         = run_flag_reg;
        changed_next          = changed_reg;
        phase_acc_next        = phase_acc_reg;
        if (cmd.load_item)
        begin
            changed_next   = 1'b0;
            phase_acc_next = phase_acc_reg + PHASE_BITS'(phase_step_reg);
            if (key != last_key_reg)
            begin
                last_key_next = key;
                unique case (key)
                    KEY_LEFT:
                    begin
                        if (spine_tenths_reg > SPINE_MIN)
                        begin
                            spine_tenths_next = spine_tenths_reg - 4'sd1;
                            changed_next      = 1'b1;
                        end
                    end
                    KEY_RIGHT:
                    begin
                        if (spine_tenths_reg < SPINE_MAX)
                        begin
                            spine_tenths_next = spine_tenths_reg + 4'sd1;
                            changed_next      = 1'b1;
                        end
                    end
                    KEY_UP:
                    begin
                        if (amplitude_tenths_reg < AMP_MAX)
                        begin
                            amplitude_tenths_next = amplitude_tenths_reg + 6'sd1;
                        end
                    end
                    KEY_DOWN:
                    begin
                        if (amplitude_tenths_reg > AMP_MIN)
                        begin
                            amplitude_tenths_next = amplitude_tenths_reg - 6'sd1;
                        end
                    end
                    KEY_STOP:  run_flag_next = 1'b0;
                    KEY_RUN:   run_flag_next = 1'b1;
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_key_reg         <= KEY_NONE;
            spine_tenths_reg     <= '0;
            amplitude_tenths_reg <= AMP_RESET;
            run_flag_reg         <= 1'b1;
            changed_reg          <= 1'b0;
            phase_acc_reg        <= '0;
        end
        else
        begin
            last_key_reg         <= last_key_next;
            spine_tenths_reg     <= spine_tenths_next;
            amplitude_tenths_reg <= amplitude_tenths_next;
            run_flag_reg         <= run_flag_next;
            changed_reg          <= changed_next;
            phase_acc_reg        <= phase_acc_next;
        end
    end

    // Table address per leg: top phase bits folded to the first quadrant.
    always_comb
    begin
        logic [WIDE_W-1:0]         wide;
        logic [SINE_ADDR_BITS-1:0] addr;
        logic [H_BITS-1:0]         h_raw;
        lane_phase[0]  = phase_acc_reg;
        lane_phase[1]  = phase_acc_reg + PHASE_BITS'(hind_phase_reg);
        lane_gain[0]   = front_gain_reg;
        lane_gain[1]   = hind_gain_reg;
        lane_offset[0] = front_offset_reg;
        lane_offset[1] = hind_offset_reg;
        for (int i = 0; i < 2; i++)
        begin
            wide        = {lane_phase[i], {SINE_ADDR_BITS{1'b0}}};
            addr        = wide[WIDE_W-1 -: SINE_ADDR_BITS];
            lane_neg[i] = addr[SINE_ADDR_BITS-1];
            h_raw       = addr[H_BITS-1:0];
            if (h_raw > QUARTER_IDX)
            begin
                lane_h[i] = H_BITS'(HALF - {1'b0, h_raw});
            end
            else
            begin
                lane_h[i] = h_raw;
            end
        end
    end

    // Magnitude of the amplitude; the sign goes with the sine sign.
    assign amp_mag = amplitude_tenths_reg[AMP_W-1] ? AMP_MAG_W'(-amplitude_tenths_reg)
                                                   : AMP_MAG_W'(amplitude_tenths_reg);

    // Leg pipeline: table read, amplitude times gain, times sine, divide by 20480.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (cmd.load_item)
            begin
                sine_mag_reg[i] <= sine_rom[lane_h[i]];
                sine_neg_reg[i] <= lane_neg[i];
            end
            if (cmd.scale)
            begin
                amp_gain_reg[i] <= AMP_GAIN_W'(amp_mag) * AMP_GAIN_W'(lane_gain[i]);
                sign_reg[i]     <= amplitude_tenths_reg[AMP_W-1] ^ sine_neg_reg[i];
            end
            if (cmd.product)
            begin
                prod_reg[i] <= PROD_W'(amp_gain_reg[i]) * PROD_W'(sine_mag_reg[i]);
            end
            if (cmd.round)
            begin
                qmul_reg[i] <= QMUL_W'(SCALED_W'(({1'b0, prod_reg[i]} + ROUND_BIAS)
                                                 >> ROUND_SHIFT)) * QMUL_W'(DIV5_RECIP);
            end
        end
    end

    // Sign, offset and saturation.
    always_comb
    begin
        logic signed [SUM_W-1:0] leg_val;
        logic signed [SUM_W-1:0] leg_sum;
        for (int i = 0; i < 2; i++)
        begin
            leg_val = SUM_W'({2'b00, qmul_reg[i][QMUL_W-1:DIV5_SHIFT]});
            if (sign_reg[i])
            begin
                leg_val = -leg_val;
            end
            leg_sum = leg_val + SUM_W'(lane_offset[i]);
            if (leg_sum > SUM_W'(POS_MAX))
            begin
                lane_result[i] = POS_MAX;
            end
            else if (leg_sum < SUM_W'(POS_MIN))
            begin
                lane_result[i] = POS_MIN;
            end
            else
            begin
                lane_result[i] = leg_sum[POS_W-1:0];
            end
        end
    end

    // Result register; stopped legs read as zero.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            front_position_reg  <= run_flag_reg ? lane_result[0] : '0;
            hind_position_reg   <= run_flag_reg ? lane_result[1] : '0;
            legs_valid_reg      <= run_flag_reg;
            spine_position_reg  <= spine_q12(spine_tenths_reg);
            spine_changed_reg   <= changed_reg;
            amplitude_level_reg <= amplitude_tenths_reg;
            is_running_reg      <= run_flag_reg;
        end
    end

    assign front_position  = front_position_reg;
    assign hind_position   = hind_position_reg;
    assign legs_valid      = legs_valid_reg;
    assign spine_position  = spine_position_reg;
    assign spine_changed   = spine_changed_reg;
    assign amplitude_level = amplitude_level_reg;
    assign is_running      = is_running_reg;

endmodule

FILE: sv/qgo_checker.sv
`timescale 1ns / 1ps
`include "quadruped_gait_oscillator_defines.svh"

module qgo_checker
    import qgo_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [POS_W-1:0]  front_position,
    input logic signed [POS_W-1:0]  hind_position,
    input logic                     legs_valid,
    input logic signed [AMP_W-1:0]  amplitude_level,
    input logic                     is_running
);

    // A stopped gait reports both legs at zero.
    `QGO_ASSERT_NOW(a_stopped_legs_zero, out_valid && !legs_valid, front_position == '0 && hind_position == '0, "legs not zero while stopped")

    // Leg targets are fresh exactly when the block runs.
    `QGO_ASSERT_NOW(a_legs_follow_run, out_valid, legs_valid == is_running, "legs_valid differs from run mode")

    // Amplitude stays inside its clamp.
    `QGO_ASSERT_NOW(a_amp_range, out_valid, amplitude_level <= AMP_MAX && amplitude_level >= AMP_MIN, "amplitude out of range")

    // A tick that transfers keeps the input closed while it is being computed.
    `QGO_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "tick taken while busy")

    // A stalled result stays offered.
    `QGO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

endmodule

bind quadruped_gait_oscillator qgo_checker u_checker (.*);

FILE: sim/quadruped_gait_oscillator_tb.sv
`timescale 1ns / 1ps

module quadruped_gait_oscillator_tb;
    import qgo_pkg::*;

    localparam int PH_W   = PHASE_BITS_DEFAULT;
    localparam int ADDR_W = SINE_ADDR_BITS_DEFAULT;

    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint LEG_DIVISOR = 64'sd20480;
    localparam longint SPINE_SCALE = 64'sd4096;
    localparam longint SPINE_DIV   = 64'sd10;

    // Indexes past the last register; writes to them must have no effect.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 82;

    // One set of joint targets as the block reports it.
    typedef struct packed {
        logic signed [POS_W-1:0] front;
        logic signed [POS_W-1:0] hind;
        logic                    legs_on;
        logic signed [POS_W-1:0] spine;
        logic                    spine_moved;
        logic signed [AMP_W-1:0] amp;
        logic                    running;
    } gait_targets_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [KEY_W-1:0]        key_code;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [POS_W-1:0] front_position;
    logic signed [POS_W-1:0] hind_position;
    logic                    legs_valid;
    logic signed [POS_W-1:0] spine_position;
    logic                    spine_changed;
    logic signed [AMP_W-1:0] amplitude_level;
    logic                    is_running;
    logic                    cfg_write;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // Local copy of the configuration registers.
    logic [STEP_W-1:0]       step_reg;
    logic [STEP_W-1:0]       hind_lead_reg;
    logic [GAIN_W-1:0]       front_gain_reg;
    logic [GAIN_W-1:0]       hind_gain_reg;
    logic signed [POS_W-1:0] front_offset_reg;
    logic signed [POS_W-1:0] hind_offset_reg;

    // Local copy of the gait state.
    logic [KEY_W-1:0]          last_tick_key;
    logic signed [SPINE_W-1:0] spine_tenths;
    logic signed [AMP_W-1:0]   amp_tenths;
    logic                      run_mode;
    logic [PH_W-1:0]           phase_acc;

    gait_targets_t pending_targets[$];
    gait_targets_t due;

    int mismatches;
    int results_checked;
    int ticks_sent;
    int reg_writes;
    int stopped_ticks;
    int saturated_legs;
    int amp_lo, amp_hi, spine_lo, spine_hi;
    int burst_left;

    quadruped_gait_oscillator i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .key_code        (key_code),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .front_position  (front_position),
        .hind_position   (hind_position),
        .legs_valid      (legs_valid),
        .spine_position  (spine_position),
        .spine_changed   (spine_changed),
        .amplitude_level (amplitude_level),
        .is_running      (is_running),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Signed division rounded half away from zero.
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // Q15 sine of a phase: the top address bits are folded into the first quadrant
    // and the angle in Q30 goes through a Taylor series up to the x^13 term.
    function automatic int sine_of_phase(input logic [PH_W-1:0] ph);
        logic [ADDR_W-1:0] addr;
        longint h;
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint r;
        int k;
        addr = ph[PH_W-1 -: ADDR_W];
        h = longint'(addr[ADDR_W-2:0]);
        if (h > (longint'(1) << (ADDR_W - 2)))
        begin
            h = (longint'(1) << (ADDR_W - 1)) - h;
        end
        x = (h * TWO_PI_Q30) / (longint'(1) << ADDR_W);
        x2 = (x * x) / Q30_ONE;
        term = x;
        sum = x;
        for (k = 1; k <= 6; k++)
        begin
            term = -(term * x2) / (longint'(2 * k) * longint'(2 * k + 1) * Q30_ONE);
            sum = sum + term;
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        r = (sum + 16384) / 32768;
        if (r > 32767)
        begin
            r = 32767;
        end
        return addr[ADDR_W-1] ? -int'(r) : int'(r);
    endfunction

    // Leg target: amplitude times gain times sine, scaled to Q12, offset and saturated.
    function automatic logic signed [POS_W-1:0] leg_target(
        input logic signed [AMP_W-1:0] amp,
        input logic [GAIN_W-1:0]       gain,
        input logic signed [POS_W-1:0] offset,
        input logic [PH_W-1:0]         ph
    );
        longint p;
        longint v;
        p = longint'(amp) * longint'(gain) * longint'(sine_of_phase(ph));
        v = round_div(p, LEG_DIVISOR) + longint'(offset);
        if (v > longint'(POS_MAX))
        begin
            v = longint'(POS_MAX);
        end
        if (v < longint'(POS_MIN))
        begin
            v = longint'(POS_MIN);
        end
        return POS_W'(v);
    endfunction

    // Apply one tick to the local gait state and queue the targets it produces.
    task automatic advance_gait(input logic [KEY_W-1:0] key);
        gait_targets_t t;
        logic [PH_W-1:0] hind_phase;
        t = '0;
        if (key != last_tick_key)
        begin
            case (key)
                KEY_LEFT:
                begin
                    if (spine_tenths > SPINE_MIN)
                    begin
                        spine_tenths = spine_tenths - 4'sd1;
                        t.spine_moved = 1'b1;
                    end
                end
                KEY_RIGHT:
                begin
                    if (spine_tenths < SPINE_MAX)
                    begin
                        spine_tenths = spine_tenths + 4'sd1;
                        t.spine_moved = 1'b1;
                    end
                end
                KEY_UP:
                begin
                    if (amp_tenths < AMP_MAX)
                    begin
                        amp_tenths = amp_tenths + 6'sd1;
                    end
                end
                KEY_DOWN:
                begin
                    if (amp_tenths > AMP_MIN)
                    begin
                        amp_tenths = amp_tenths - 6'sd1;
                    end
                end
                KEY_STOP: run_mode = 1'b0;
                KEY_RUN:  run_mode = 1'b1;
                default:  ;
            endcase
            last_tick_key = key;
        end

        if (run_mode)
        begin
            hind_phase = phase_acc + hind_lead_reg;
            t.front = leg_target(amp_tenths, front_gain_reg, front_offset_reg, phase_acc);
            t.hind  = leg_target(amp_tenths, hind_gain_reg, hind_offset_reg, hind_phase);
            saturated_legs += int'(t.front == POS_MAX || t.front == POS_MIN);
            saturated_legs += int'(t.hind == POS_MAX || t.hind == POS_MIN);
        end
        else
        begin
            stopped_ticks++;
        end
        phase_acc = phase_acc + step_reg;

        t.legs_on = run_mode;
        t.running = run_mode;
        t.amp     = amp_tenths;
        t.spine   = POS_W'(round_div(longint'(spine_tenths) * SPINE_SCALE, SPINE_DIV));
        pending_targets.push_back(t);

        if (int'(amp_tenths) < amp_lo) amp_lo = int'(amp_tenths);
        if (int'(amp_tenths) > amp_hi) amp_hi = int'(amp_tenths);
        if (int'(spine_tenths) < spine_lo) spine_lo = int'(spine_tenths);
        if (int'(spine_tenths) > spine_hi) spine_hi = int'(spine_tenths);
    endtask

    // Write one register through the configuration port; the block must be idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_PHASE_STEP:   step_reg = data[STEP_W-1:0];
            CFG_HIND_PHASE:   hind_lead_reg = data[STEP_W-1:0];
            CFG_FRONT_GAIN:   front_gain_reg = data[GAIN_W-1:0];
            CFG_HIND_GAIN:    hind_gain_reg = data[GAIN_W-1:0];
            CFG_FRONT_OFFSET: front_offset_reg = data[POS_W-1:0];
            CFG_HIND_OFFSET:  hind_offset_reg = data[POS_W-1:0];
            default:          ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Send one tick. Ticks go out in bursts of random length with random gaps;
    // the task returns at the edge where the transfer happens.
    task automatic send_key(input logic [KEY_W-1:0] key);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                key_code <= KEY_W'($urandom_range(0, 7));
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        key_code <= key;
        burst_left--;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        advance_gait(key);
        ticks_sent++;
    endtask

    // Drop valid right after the last transfer, then wait until every result is
    // back and the pipeline has had time to settle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_targets.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register value with random upper bits; the field itself is its lowest
    // value, its highest value or random.
    function automatic logic [CFG_DATA_W-1:0] shaped_reg_value(input int width,
                                                              input bit is_signed);
        logic [CFG_DATA_W-1:0] v;
        logic [CFG_DATA_W-1:0] field_mask;
        v = CFG_DATA_W'($urandom_range(0, 65535));
        field_mask = CFG_DATA_W'((32'd1 << width) - 32'd1);
        case ($urandom_range(0, 3))
            0: v = (v & ~field_mask) | (is_signed ? (CFG_DATA_W'(1) << (width - 1)) : '0);
            1: v = (v & ~field_mask) | (is_signed ? (field_mask >> 1) : field_mask);
            default: ;
        endcase
        return v;
    endfunction

    // Every key once, repeated keys, and keys that change but do nothing.
    task automatic test_key_actions();
        send_key(KEY_NONE);
        send_key(KEY_OTHER);
        send_key(KEY_OTHER);
        send_key(KEY_LEFT);
        send_key(KEY_LEFT);
        send_key(KEY_RIGHT);
        send_key(KEY_UP);
        send_key(KEY_UP);
        send_key(KEY_DOWN);
        send_key(KEY_NONE);
        send_key(KEY_DOWN);
        send_key(KEY_STOP);
        send_key(KEY_LEFT);
        send_key(KEY_UP);
        send_key(KEY_RUN);
        send_key(KEY_RUN);
        wait_idle();
    endtask

    // Register extremes, junk in the unused upper bits, and writes to spare indexes.
    task automatic test_register_limits();
        // Largest gains and the extreme offsets: legs saturate, phase wraps every tick.
        write_reg(CFG_PHASE_STEP, 16'hFFFF);
        write_reg(CFG_HIND_PHASE, 16'hFFFF);
        write_reg(CFG_FRONT_GAIN, 16'hA5FF);
        write_reg(CFG_HIND_GAIN, 16'hFFFF);
        write_reg(CFG_FRONT_OFFSET, {2'b11, 14'h1FFF});
        write_reg(CFG_HIND_OFFSET, {2'b01, 14'h2000});
        send_key(KEY_UP);
        send_key(KEY_NONE);
        send_key(KEY_UP);
        send_key(KEY_OTHER);
        wait_idle();

        // Zero gains and a frozen phase: legs sit exactly on their offsets.
        write_reg(CFG_PHASE_STEP, 16'h0000);
        write_reg(CFG_HIND_PHASE, 16'h0000);
        write_reg(CFG_FRONT_GAIN, 16'h5A00);
        write_reg(CFG_HIND_GAIN, 16'h0000);
        write_reg(CFG_FRONT_OFFSET, {2'b10, 14'h2000});
        write_reg(CFG_HIND_OFFSET, {2'b00, 14'h1FFF});
        send_key(KEY_NONE);
        send_key(KEY_DOWN);
        wait_idle();

        // Writes past the last register must leave everything unchanged.
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'h0000);
        send_key(KEY_OTHER);
        send_key(KEY_NONE);
        wait_idle();
    endtask

    // Press one stepping key repeatedly, separated by other keys, to drive the
    // spine or the amplitude into its limit.
    task automatic send_sweep(input int presses);
        logic [KEY_W-1:0] push;
        logic [KEY_W-1:0] filler;
        case ($urandom_range(0, 3))
            0:       push = KEY_LEFT;
            1:       push = KEY_RIGHT;
            2:       push = KEY_UP;
            default: push = KEY_DOWN;
        endcase
        for (int i = 0; i < presses; i++)
        begin
            send_key(push);
            if ($urandom_range(0, 3) != 0)
            begin
                filler = $urandom_range(0, 1) ? KEY_NONE : KEY_OTHER;
            end
            else
            begin
                do
                begin
                    filler = KEY_W'($urandom_range(0, 7));
                end
                while (filler == push);
            end
            send_key(filler);
        end
    endtask

    // Random phases, each under a new register setting, built from sweeps,
    // held keys, stop and run episodes, and plain random keys.
    task automatic test_random_traffic();
        int target;
        logic [KEY_W-1:0] held;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_reg(CFG_PHASE_STEP, shaped_reg_value(STEP_W, 1'b0));
            write_reg(CFG_HIND_PHASE, shaped_reg_value(STEP_W, 1'b0));
            write_reg(CFG_FRONT_GAIN, shaped_reg_value(GAIN_W, 1'b0));
            write_reg(CFG_HIND_GAIN, shaped_reg_value(GAIN_W, 1'b0));
            write_reg(CFG_FRONT_OFFSET, shaped_reg_value(POS_W, 1'b1));
            write_reg(CFG_HIND_OFFSET, shaped_reg_value(POS_W, 1'b1));
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          CFG_DATA_W'($urandom_range(0, 65535)));
            end

            target = ticks_sent + PHASE_TICKS;
            while (ticks_sent < target)
            begin
                case ($urandom_range(0, 4))
                    0, 1: send_sweep($urandom_range(3, 40));
                    2:
                    begin
                        held = KEY_W'($urandom_range(0, 7));
                        repeat ($urandom_range(2, 8)) send_key(held);
                    end
                    3:
                    begin
                        send_key(KEY_STOP);
                        repeat ($urandom_range(1, 6)) send_key(KEY_W'($urandom_range(0, 7)));
                        send_key(KEY_RUN);
                    end
                    default:
                    begin
                        repeat ($urandom_range(4, 20)) send_key(KEY_W'($urandom_range(0, 7)));
                    end
                endcase
            end
            wait_idle();
        end
    endtask

    // Receiver: alternating runs of stalls and free cycles, some of them long.
    initial
    begin : receiver_pattern
        int run_len;
        bit hold;
        out_stall = 1'b0;
        run_len = 0;
        hold = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run_len == 0)
            begin
                hold = !hold;
                if (hold)
                begin
                    run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24)
                                                          : $urandom_range(1, 4);
                end
                else
                begin
                    run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 10);
                end
                out_stall <= hold;
            end
            run_len--;
        end
    end

    // Compare each result transfer with the oldest expected targets.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (pending_targets.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("Unexpected result at %0t: front %0d hind %0d spine %0d",
                             $time, front_position, hind_position, spine_position);
                end
                mismatches++;
            end
            else
            begin
                due = pending_targets.pop_front();
                if (front_position !== due.front || hind_position !== due.hind ||
                    legs_valid !== due.legs_on || spine_position !== due.spine ||
                    spine_changed !== due.spine_moved || amplitude_level !== due.amp ||
                    is_running !== due.running)
                begin
                    if (mismatches < 10)
                    begin
                        $display("Mismatch at %0t: expected front %0d hind %0d legs %0b spine %0d moved %0b amp %0d run %0b",
                                 $time, due.front, due.hind, due.legs_on, due.spine,
                                 due.spine_moved, due.amp, due.running);
                        $display("               got      front %0d hind %0d legs %0b spine %0d moved %0b amp %0d run %0b",
                                 front_position, hind_position, legs_valid, spine_position,
                                 spine_changed, amplitude_level, is_running);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run if no transfer happens for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_targets.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : main_sequence
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        key_code  = KEY_NONE;
        cfg_write = 1'b0;
        cfg_index = CFG_PHASE_STEP;
        cfg_data  = '0;

        step_reg         = PHASE_STEP_RESET;
        hind_lead_reg    = HIND_PHASE_RESET;
        front_gain_reg   = FRONT_GAIN_RESET;
        hind_gain_reg    = HIND_GAIN_RESET;
        front_offset_reg = FRONT_OFFSET_RESET;
        hind_offset_reg  = HIND_OFFSET_RESET;
        last_tick_key    = KEY_NONE;
        spine_tenths     = '0;
        amp_tenths       = AMP_RESET;
        run_mode         = 1'b1;
        phase_acc        = '0;

        mismatches      = 0;
        results_checked = 0;
        ticks_sent      = 0;
        reg_writes      = 0;
        stopped_ticks   = 0;
        saturated_legs  = 0;
        amp_lo          = int'(AMP_RESET);
        amp_hi          = int'(AMP_RESET);
        spine_lo        = 0;
        spine_hi        = 0;
        burst_left      = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_key_actions();
        test_register_limits();
        test_random_traffic();
        wait_idle();

        $display("Checked %0d results from %0d ticks over %0d register writes; %0d ticks stopped, %0d leg targets saturated.",
                 results_checked, ticks_sent, reg_writes, stopped_ticks, saturated_legs);
        $display("Amplitude ranged over %0d..%0d tenths and spine over %0d..%0d tenths.",
                 amp_lo, amp_hi, spine_lo, spine_hi);
        if (mismatches == 0 && pending_targets.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
